FILE: rtl/fcl_pkg.sv
// Frame checker link watchdog: shared types, codes and constants.
// No dependencies; every other file imports this package.
package fcl_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int CNT_W       = 5;
    localparam int ADDR_W      = 3;

    localparam logic       REQ_BYTE = 1'b0;
    localparam logic       REQ_TICK = 1'b1;

    localparam logic [1:0] EV_GOOD    = 2'd0;
    localparam logic [1:0] EV_RESTORE = 2'd1;
    localparam logic [1:0] EV_LOST    = 2'd2;

    localparam logic [1:0] RS_STOP  = 2'd0;
    localparam logic [1:0] RS_RUN   = 2'd1;
    localparam logic [1:0] RS_PAUSE = 2'd2;

    localparam logic [7:0] HDR0 = 8'hAB;
    localparam logic [7:0] HDR1 = 8'hBA;

    localparam logic [7:0] TIMEOUT_RST = 8'd60;
    localparam logic [7:0] TICKS_RST   = 8'd59;
    localparam logic [7:0] TICKS_MAX   = 8'hFF;

    localparam logic [ADDR_W-3:0] REG_TIMEOUT = '0;

    // x / 100 == (x * DIV_RECIP) >> DIV_SHIFT for all 32-bit x
    localparam logic [31:0] DIV_RECIP = 32'h51EB_851F;
    localparam int          DIV_SHIFT = 37;
    localparam logic [31:0] DIVISOR   = 32'd100;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [25:0] first_whole;
        logic [6:0]  first_hundredths;
        logic [25:0] second_whole;
        logic [6:0]  second_hundredths;
        logic [7:0]  hour_byte;
        logic [7:0]  minute_byte;
        logic [7:0]  second_byte;
        logic [7:0]  day_byte;
        logic [7:0]  month_byte;
        logic [7:0]  year_offset;
        logic [1:0]  run_state;
    } t_out_item;

    // classified event handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [7:0]  year;
        logic [1:0]  run_state;
    } t_cmd;

endpackage

FILE: rtl/fcl_if.sv
// Valid/ready channel interfaces for input and result transactions.
// Depends on fcl_pkg.
interface fcl_in_if import fcl_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fcl_out_if import fcl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/fcl_fifo.sv
// Small command queue between the front and back parts.
// Depends on fcl_pkg (t_cmd).
module fcl_fifo import fcl_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count mismatch");

endmodule

FILE: rtl/fcl_front.sv
// Front part: byte framing, header and checksum check, link timer.
// Pushes classified events into the queue. Depends on fcl_pkg, fcl_if.
module fcl_front import fcl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fcl_in_if.sink       i_in,
    input  logic [7:0]   i_timeout,
    input  logic         i_full,
    output logic         o_push,
    output t_cmd         o_cmd
);
    logic [CNT_W-1:0] r_byte_count;
    logic [7:0]       r_sum;
    logic [7:0]       r_ticks, n_ticks;
    logic             r_down, n_down;
    logic [7:0]       r_frame [FRAME_BYTES];

    logic       accept, is_tick, last_byte, good, lost;
    logic [7:0] b;
    logic [7:0] tick_inc;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign is_tick    = (i_in.payload.req_type == REQ_TICK);
    assign b          = i_in.payload.data_byte;
    assign last_byte  = (r_byte_count == CNT_W'(FRAME_BYTES - 1));

    assign good = accept && !is_tick && last_byte && (r_frame[0] == HDR0)
                  && (r_frame[1] == HDR1) && (r_sum == b);
    assign tick_inc = (r_ticks == TICKS_MAX) ? r_ticks : r_ticks + 8'd1;
    assign lost     = accept && is_tick && (tick_inc > i_timeout) && !r_down;

    always_comb begin
        n_ticks = r_ticks;
        n_down  = r_down;
        if (accept && is_tick) begin
            n_ticks = tick_inc;
            if (lost) begin
                n_down = 1'b1;
            end
        end else if (good) begin
            n_ticks = '0;
            n_down  = 1'b0;
        end
    end

    always_comb begin
        o_cmd = '0;
        if (good) begin
            o_cmd.kind   = r_down ? EV_RESTORE : EV_GOOD;
            o_cmd.word_a = {r_frame[5], r_frame[4], r_frame[3], r_frame[2]};
            o_cmd.word_b = {r_frame[9], r_frame[8], r_frame[7], r_frame[6]};
            o_cmd.hour   = r_frame[13];
            o_cmd.minute = r_frame[14];
            o_cmd.second = r_frame[15];
            o_cmd.day    = r_frame[10];
            o_cmd.month  = r_frame[11];
            o_cmd.year   = r_frame[12];
            if (r_frame[16] == 8'(RS_RUN)) begin
                o_cmd.run_state = RS_RUN;
            end else if (r_frame[16] == 8'(RS_PAUSE)) begin
                o_cmd.run_state = RS_PAUSE;
            end else begin
                o_cmd.run_state = RS_STOP;
            end
        end else begin
            o_cmd.kind = EV_LOST;
        end
    end

    assign o_push = good || lost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_sum        <= '0;
            r_ticks      <= TICKS_RST;
            r_down       <= 1'b0;
        end else begin
            r_ticks <= n_ticks;
            r_down  <= n_down;
            if (accept && !is_tick) begin
                if (last_byte) begin
                    r_byte_count <= '0;
                    r_sum        <= '0;
                end else begin
                    r_byte_count <= r_byte_count + 1'b1;
                    r_sum        <= r_sum + b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_tick) begin
            r_frame[r_byte_count] <= b;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count < CNT_W'(FRAME_BYTES))
        else $error("byte count out of frame");
    a_lost_sets_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lost |=> r_down)
        else $error("link-lost without link down");
    a_good_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        good |=> (r_ticks == '0) && !r_down)
        else $error("good frame did not clear link timer");

endmodule

FILE: rtl/fcl_back.sv
// Back part: splits the two words into whole and hundredths with a
// reciprocal multiply, then a remainder stage feeding the output register.
// Depends on fcl_pkg, fcl_if.
module fcl_back import fcl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    fcl_out_if.source o_out
);
    logic        r_s1_v;
    t_cmd        r_s1;
    logic [25:0] r_s1_qa, r_s1_qb;
    logic        r_o_v;
    t_out_item   r_o;

    logic        o_adv, s1_ready;
    logic [63:0] prod_a, prod_b;
    logic [31:0] rem_a, rem_b;

    assign o_adv    = !r_o_v || o_out.ready;
    assign s1_ready = !r_s1_v || o_adv;
    assign o_pop    = i_valid && s1_ready;

    assign prod_a = {32'd0, i_cmd.word_a} * {32'd0, DIV_RECIP};
    assign prod_b = {32'd0, i_cmd.word_b} * {32'd0, DIV_RECIP};

    assign rem_a = r_s1.word_a - 32'(r_s1_qa) * DIVISOR;
    assign rem_b = r_s1.word_b - 32'(r_s1_qb) * DIVISOR;

    assign o_out.valid   = r_o_v;
    assign o_out.payload = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= i_valid;
            end
            if (o_adv) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1    <= i_cmd;
            r_s1_qa <= prod_a[DIV_SHIFT+25:DIV_SHIFT];
            r_s1_qb <= prod_b[DIV_SHIFT+25:DIV_SHIFT];
        end
        if (o_adv && r_s1_v) begin
            r_o.event_kind        <= r_s1.kind;
            r_o.first_whole       <= r_s1_qa;
            r_o.first_hundredths  <= rem_a[6:0];
            r_o.second_whole      <= r_s1_qb;
            r_o.second_hundredths <= rem_b[6:0];
            r_o.hour_byte         <= r_s1.hour;
            r_o.minute_byte       <= r_s1.minute;
            r_o.second_byte       <= r_s1.second;
            r_o.day_byte          <= r_s1.day;
            r_o.month_byte        <= r_s1.month;
            r_o.year_offset       <= r_s1.year;
            r_o.run_state         <= r_s1.run_state;
        end
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_o.first_hundredths < 7'd100) && (r_o.second_hundredths < 7'd100))
        else $error("remainder out of range");
    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o.event_kind == EV_LOST) |->
            (r_o.first_whole == '0) && (r_o.second_whole == '0) && (r_o.run_state == RS_STOP))
        else $error("link-lost result carries data");
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_ready) |=> r_s1_v && $stable(r_s1))
        else $error("stalled stage lost its command");

endmodule

FILE: rtl/frame_checker_link_watchdog_core.sv
// Frame checker with link watchdog: takes received bytes and timer ticks, one
// transaction per cycle while the queue is not full, and counts bytes into
// 18-byte frames aligned by count. A frame with header 0xAB 0xBA and a
// matching additive checksum in its last byte gives one result carrying its
// two words split by 100, time, date and run state; other frames are dropped.
// Ticks advance a saturating link timer; passing the timeout register raises
// one link-lost result, and the next good frame is flagged as a restore. A
// result passes through the queue, the reciprocal multiply stage and the output
// register; the sustained rate is one transaction per cycle while the output
// does not stall, and a four-entry queue lets input continue while it stalls.
// Depends on fcl_pkg, fcl_if, fcl_fifo, fcl_front, fcl_back.
module frame_checker_link_watchdog_core import fcl_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fcl_in_if.sink            i_in,
    fcl_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [7:0]        r_timeout;
    logic [ADDR_W-3:0] reg_idx;
    logic              q_full, q_push, q_pop, q_valid;
    t_cmd              q_in, q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign prdata  = (reg_idx == REG_TIMEOUT) ? {24'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && reg_idx == REG_TIMEOUT) begin
            r_timeout <= pwdata[7:0];
        end
    end

    fcl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_timeout (r_timeout),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    fcl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    fcl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
